### sv/eth_vlan_ipv4_l4_header_parser_core_macros.svh
// assertion macros for the header parser
`ifndef ETH_VLAN_IPV4_L4_HEADER_PARSER_CORE_MACROS_SVH
`define ETH_VLAN_IPV4_L4_HEADER_PARSER_CORE_MACROS_SVH

// same-cycle implication
`define EVL4_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EVL4_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/evl4_pkg.sv
// shared constants and status codes for the header parser
package evl4_pkg;

    localparam logic [15:0] ETYPE_CTAG = 16'h8100;
    localparam logic [15:0] ETYPE_STAG = 16'h88A8;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam int ETH_HDR_LEN   = 14;
    localparam int VLAN_TAG_LEN  = 4;
    localparam int IP_HDR_MAX    = 60;
    localparam int UDP_HDR_LEN   = 8;
    localparam int TCP_HDR_MIN   = 20;

    localparam logic [3:0] IHL_MIN     = 4'd5;
    localparam logic [3:0] TCP_OFF_MIN = 4'd5;

    typedef enum logic [3:0] {
        ST_L4_OK       = 4'd0,
        ST_NON_IPV4    = 4'd1,
        ST_OTHER_PROTO = 4'd2,
        ST_ETH_SHORT   = 4'd3,
        ST_VLAN_OVF    = 4'd4,
        ST_IP_SHORT    = 4'd5,
        ST_FRAGMENT    = 4'd6,
        ST_BAD_IHL     = 4'd7,
        ST_L4_SHORT    = 4'd8,
        ST_BAD_TCP_OFF = 4'd9
    } status_t;

    localparam int OUT_DATA_BITS = 168;

endpackage

### sv/eth_vlan_ipv4_l4_header_parser_core.sv
// ethernet / vlan / ipv4 / tcp-udp header parser, one byte per beat
//
//  channel   dir  width  contents
//  s_axis    in   8+1    packet byte in tdata, tlast on the final byte
//  m_axis    out  168    one parse result per packet, tdata fields listed at the port
//
//  one byte per cycle while the input register is not stalled; a byte is first captured
//  in the input register, then folded into the parser state, and a last byte loads the
//  result register in the same cycle as it is folded
//  the input register only stalls when it holds a last byte and the result register is full
//  rst_n is asynchronous and clears the parser, input and result registers
//  byte offsets saturate at 2^LENGTH_BITS - 1; lengths and offsets leave as 16 bits
`include "eth_vlan_ipv4_l4_header_parser_core_macros.svh"

module eth_vlan_ipv4_l4_header_parser_core
    import evl4_pkg::*;
#(
    parameter int MAX_VLAN_TAGS = 2,
    parameter int LENGTH_BITS   = 16
)
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,   // last_byte

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [3:0] status, [19:4] ethertype, [51:20] src_addr, [83:52] dst_addr,
    // [91:84] ip_proto, [107:92] src_port_out, [123:108] dst_port_out,
    // [131:124] flags_out, [147:132] payload_start, [163:148] trimmed_length,
    // [167:164] zero
    output logic [167:0] m_axis_tdata
);

    // widths that follow from the tag bound and the length counter
    localparam int VW   = $clog2(MAX_VLAN_TAGS + 1);
    localparam int L3W  = $clog2(ETH_HDR_LEN + VLAN_TAG_LEN * MAX_VLAN_TAGS + 1);
    localparam int L4W  = $clog2(ETH_HDR_LEN + VLAN_TAG_LEN * MAX_VLAN_TAGS + IP_HDR_MAX + 1);
    localparam int LW   = LENGTH_BITS;
    localparam int SW   = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 1;

    localparam logic [LW-1:0] LEN_MAX = {LW{1'b1}};

    typedef enum logic [3:0] {
        PH_ETH,
        PH_VLAN,
        PH_IPH,
        PH_IPOPT,
        PH_TCP,
        PH_UDP,
        PH_NONIP,
        PH_OTHER,
        PH_OVF,
        PH_FRAG,
        PH_IHL
    } phase_t;

    // input register
    logic           in_valid_reg;
    logic [7:0]     in_byte_reg;
    logic           in_last_reg;

    // parser state
    phase_t         phase_reg,      phase_next;
    logic [LW-1:0]  byte_count_reg, byte_count_next;
    logic [VW-1:0]  vlan_seen_reg,  vlan_seen_next;
    logic [15:0]    type_reg,       type_next;
    logic [L3W-1:0] l3_begin_reg,   l3_begin_next;
    logic [L4W-1:0] l4_begin_reg,   l4_begin_next;
    logic [3:0]     ihl_reg,        ihl_next;
    logic [15:0]    total_len_reg,  total_len_next;
    logic [13:0]    frag_reg,       frag_next;
    logic [7:0]     proto_reg,      proto_next;
    logic [31:0]    src_addr_reg,   src_addr_next;
    logic [31:0]    dst_addr_reg,   dst_addr_next;
    logic [15:0]    src_port_reg,   src_port_next;
    logic [15:0]    dst_port_reg,   dst_port_next;
    logic [3:0]     tcp_off_reg,    tcp_off_next;
    logic [7:0]     tcp_flags_reg,  tcp_flags_next;

    // result register
    logic           out_valid_reg;
    status_t        res_status_reg, res_status_next;
    logic [15:0]    res_pay_reg,    res_pay_next;
    logic [15:0]    res_trim_reg,   res_trim_next;
    logic [15:0]    res_etype_reg;
    logic [31:0]    res_src_reg;
    logic [31:0]    res_dst_reg;
    logic [7:0]     res_proto_reg;
    logic [15:0]    res_sport_reg;
    logic [15:0]    res_dport_reg;
    logic [7:0]     res_flags_reg;

    // handshake
    logic           out_free;
    logic           proc_fire;

    // datapath helpers
    logic [LW-1:0]  rel3;
    logic [LW-1:0]  rel4;
    logic           do_decide;
    logic           do_dispatch;
    phase_t         dispatch_phase;
    logic [SW-1:0]  len_ext;
    logic [SW-1:0]  limit;
    logic [SW-1:0]  trim_ip;
    logic [SW-1:0]  l3_ext;
    logic [SW-1:0]  l4_ext;
    logic [SW-1:0]  udp_end;
    logic [SW-1:0]  tcp_min_end;
    logic [SW-1:0]  tcp_end;
    logic [SW-1:0]  pay_full;
    logic [SW-1:0]  trim_full;

    // a byte is folded in unless it is a last byte facing a full result register
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proc_fire     = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || proc_fire;

    // l4 dispatch on the captured protocol byte
    always_comb
    begin
        if (proto_reg == PROTO_TCP)
            dispatch_phase = PH_TCP;
        else if (proto_reg == PROTO_UDP)
            dispatch_phase = PH_UDP;
        else
            dispatch_phase = PH_OTHER;
    end

    // next parser state for the byte in the input register
    always_comb
    begin
        phase_next      = phase_reg;
        vlan_seen_next  = vlan_seen_reg;
        type_next       = type_reg;
        l3_begin_next   = l3_begin_reg;
        l4_begin_next   = l4_begin_reg;
        ihl_next        = ihl_reg;
        total_len_next  = total_len_reg;
        frag_next       = frag_reg;
        proto_next      = proto_reg;
        src_addr_next   = src_addr_reg;
        dst_addr_next   = dst_addr_reg;
        src_port_next   = src_port_reg;
        dst_port_next   = dst_port_reg;
        tcp_off_next    = tcp_off_reg;
        tcp_flags_next  = tcp_flags_reg;
        do_decide       = 1'b0;
        do_dispatch     = 1'b0;

        byte_count_next = (byte_count_reg != LEN_MAX) ? byte_count_reg + LW'(1) : byte_count_reg;
        // offsets within the current header; the count never lags the header start here
        rel3 = byte_count_reg - LW'(l3_begin_reg);
        rel4 = byte_count_reg - LW'(l4_begin_reg);

        case (phase_reg)
            PH_ETH:
            begin
                if (byte_count_reg == LW'(12))
                    type_next = {in_byte_reg, 8'h00};
                else if (byte_count_reg == LW'(13))
                begin
                    type_next     = {type_reg[15:8], in_byte_reg};
                    l3_begin_next = L3W'(ETH_HDR_LEN);
                    do_decide     = 1'b1;
                end
            end
            PH_VLAN:
            begin
                if (rel3 == LW'(2))
                    type_next = {in_byte_reg, 8'h00};
                else if (rel3 == LW'(3))
                begin
                    type_next      = {type_reg[15:8], in_byte_reg};
                    l3_begin_next  = l3_begin_reg + L3W'(VLAN_TAG_LEN);
                    vlan_seen_next = vlan_seen_reg + VW'(1);
                    do_decide      = 1'b1;
                end
            end
            PH_IPH:
            begin
                if (rel3 == LW'(0))
                    ihl_next = in_byte_reg[3:0];
                else if (rel3 == LW'(2))
                    total_len_next = {in_byte_reg, 8'h00};
                else if (rel3 == LW'(3))
                    total_len_next = {total_len_reg[15:8], in_byte_reg};
                else if (rel3 == LW'(6))
                    frag_next = {in_byte_reg[5:0], 8'h00};
                else if (rel3 == LW'(7))
                    frag_next = {frag_reg[13:8], in_byte_reg};
                else if (rel3 == LW'(9))
                    proto_next = in_byte_reg;
                else if (rel3 >= LW'(12) && rel3 <= LW'(15))
                    src_addr_next = {src_addr_reg[23:0], in_byte_reg};
                else if (rel3 >= LW'(16) && rel3 <= LW'(19))
                    dst_addr_next = {dst_addr_reg[23:0], in_byte_reg};

                // twentieth header byte: fragment, then ihl, then dispatch or options
                if (rel3 == LW'(19))
                begin
                    if (frag_reg != 14'd0)
                        phase_next = PH_FRAG;
                    else if (ihl_reg < IHL_MIN)
                        phase_next = PH_IHL;
                    else
                    begin
                        l4_begin_next = L4W'(l3_begin_reg) + L4W'({ihl_reg, 2'b00});
                        if (ihl_reg == IHL_MIN)
                            do_dispatch = 1'b1;
                        else
                            phase_next = PH_IPOPT;
                    end
                end
            end
            PH_IPOPT:
            begin
                if ({1'b0, byte_count_reg} + (LW+1)'(1) >= (LW+1)'(l4_begin_reg))
                    do_dispatch = 1'b1;
            end
            PH_TCP, PH_UDP:
            begin
                if (rel4 <= LW'(1))
                    src_port_next = {src_port_reg[7:0], in_byte_reg};
                else if (rel4 <= LW'(3))
                    dst_port_next = {dst_port_reg[7:0], in_byte_reg};
                else if (phase_reg == PH_TCP && rel4 == LW'(12))
                    tcp_off_next = in_byte_reg[7:4];
                else if (phase_reg == PH_TCP && rel4 == LW'(13))
                    tcp_flags_next = in_byte_reg;
            end
            default:
            begin
            end
        endcase

        // ethertype decision after the outer header or a tag
        if (do_decide)
        begin
            if (type_next == ETYPE_CTAG || type_next == ETYPE_STAG)
                phase_next = (vlan_seen_next >= VW'(MAX_VLAN_TAGS)) ? PH_OVF : PH_VLAN;
            else if (type_next == ETYPE_IPV4)
                phase_next = PH_IPH;
            else
                phase_next = PH_NONIP;
        end

        if (do_dispatch)
            phase_next = dispatch_phase;
    end

    // result for a last byte, taken from the updated state
    always_comb
    begin
        len_ext     = SW'(byte_count_next);
        l3_ext      = SW'(l3_begin_next);
        l4_ext      = SW'(l4_begin_next);
        limit       = l3_ext + SW'(total_len_next);
        trim_ip     = (limit < len_ext) ? limit : len_ext;
        udp_end     = l4_ext + SW'(UDP_HDR_LEN);
        tcp_min_end = l4_ext + SW'(TCP_HDR_MIN);
        tcp_end     = l4_ext + SW'({tcp_off_next, 2'b00});

        pay_full        = l3_ext;
        trim_full       = len_ext;
        res_status_next = ST_IP_SHORT;

        case (phase_next)
            PH_ETH:
            begin
                res_status_next = ST_ETH_SHORT;
                pay_full        = '0;
            end
            PH_VLAN:  res_status_next = ST_ETH_SHORT;
            PH_NONIP: res_status_next = ST_NON_IPV4;
            PH_OVF:   res_status_next = ST_VLAN_OVF;
            PH_FRAG:  res_status_next = ST_FRAGMENT;
            PH_IHL:   res_status_next = ST_BAD_IHL;
            PH_IPH, PH_IPOPT:
                res_status_next = ST_IP_SHORT;
            PH_OTHER:
            begin
                res_status_next = ST_OTHER_PROTO;
                pay_full        = l4_ext;
                trim_full       = trim_ip;
            end
            PH_UDP:
            begin
                trim_full = trim_ip;
                if (trim_ip < udp_end)
                begin
                    res_status_next = ST_L4_SHORT;
                    pay_full        = l4_ext;
                end
                else
                begin
                    res_status_next = ST_L4_OK;
                    pay_full        = udp_end;
                end
            end
            PH_TCP:
            begin
                trim_full = trim_ip;
                pay_full  = l4_ext;
                if (trim_ip < tcp_min_end)
                    res_status_next = ST_L4_SHORT;
                else if (tcp_off_next < TCP_OFF_MIN)
                    res_status_next = ST_BAD_TCP_OFF;
                else if (trim_ip < tcp_end)
                    res_status_next = ST_L4_SHORT;
                else
                begin
                    res_status_next = ST_L4_OK;
                    pay_full        = tcp_end;
                end
            end
            default:
            begin
                res_status_next = ST_IP_SHORT;
            end
        endcase

        res_pay_next  = pay_full[15:0];
        res_trim_next = trim_full[15:0];
    end

    // input register, parser state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            in_byte_reg    <= '0;
            in_last_reg    <= 1'b0;
            phase_reg      <= PH_ETH;
            byte_count_reg <= '0;
            vlan_seen_reg  <= '0;
            type_reg       <= '0;
            l3_begin_reg   <= '0;
            l4_begin_reg   <= '0;
            ihl_reg        <= '0;
            total_len_reg  <= '0;
            frag_reg       <= '0;
            proto_reg      <= '0;
            src_addr_reg   <= '0;
            dst_addr_reg   <= '0;
            src_port_reg   <= '0;
            dst_port_reg   <= '0;
            tcp_off_reg    <= '0;
            tcp_flags_reg  <= '0;
            out_valid_reg  <= 1'b0;
            res_status_reg <= ST_L4_OK;
            res_pay_reg    <= '0;
            res_trim_reg   <= '0;
            res_etype_reg  <= '0;
            res_src_reg    <= '0;
            res_dst_reg    <= '0;
            res_proto_reg  <= '0;
            res_sport_reg  <= '0;
            res_dport_reg  <= '0;
            res_flags_reg  <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
                if (s_axis_tvalid)
                begin
                    in_byte_reg <= s_axis_tdata;
                    in_last_reg <= s_axis_tlast;
                end
            end

            if (proc_fire && in_last_reg)
            begin
                // packet done: start clean for the next one
                phase_reg      <= PH_ETH;
                byte_count_reg <= '0;
                vlan_seen_reg  <= '0;
                type_reg       <= '0;
                l3_begin_reg   <= '0;
                l4_begin_reg   <= '0;
                ihl_reg        <= '0;
                total_len_reg  <= '0;
                frag_reg       <= '0;
                proto_reg      <= '0;
                src_addr_reg   <= '0;
                dst_addr_reg   <= '0;
                src_port_reg   <= '0;
                dst_port_reg   <= '0;
                tcp_off_reg    <= '0;
                tcp_flags_reg  <= '0;
            end
            else if (proc_fire)
            begin
                phase_reg      <= phase_next;
                byte_count_reg <= byte_count_next;
                vlan_seen_reg  <= vlan_seen_next;
                type_reg       <= type_next;
                l3_begin_reg   <= l3_begin_next;
                l4_begin_reg   <= l4_begin_next;
                ihl_reg        <= ihl_next;
                total_len_reg  <= total_len_next;
                frag_reg       <= frag_next;
                proto_reg      <= proto_next;
                src_addr_reg   <= src_addr_next;
                dst_addr_reg   <= dst_addr_next;
                src_port_reg   <= src_port_next;
                dst_port_reg   <= dst_port_next;
                tcp_off_reg    <= tcp_off_next;
                tcp_flags_reg  <= tcp_flags_next;
            end

            if (proc_fire && in_last_reg)
            begin
                out_valid_reg  <= 1'b1;
                res_status_reg <= res_status_next;
                res_pay_reg    <= res_pay_next;
                res_trim_reg   <= res_trim_next;
                res_etype_reg  <= type_next;
                res_src_reg    <= src_addr_next;
                res_dst_reg    <= dst_addr_next;
                res_proto_reg  <= proto_next;
                res_sport_reg  <= src_port_next;
                res_dport_reg  <= dst_port_next;
                res_flags_reg  <= tcp_flags_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000,
                            res_trim_reg,
                            res_pay_reg,
                            res_flags_reg,
                            res_dport_reg,
                            res_sport_reg,
                            res_proto_reg,
                            res_dst_reg,
                            res_src_reg,
                            res_etype_reg,
                            res_status_reg};

    // checks on the parser's own control
    `EVL4_ASSERT_NEXT(a_last_loads_result, clk, rst_n, proc_fire && in_last_reg,
        out_valid_reg, "last byte did not load the result register")
    `EVL4_ASSERT_NEXT(a_last_clears_state, clk, rst_n, proc_fire && in_last_reg,
        phase_reg == PH_ETH && byte_count_reg == '0 && vlan_seen_reg == '0,
        "parser state not cleared after last byte")
    `EVL4_ASSERT_NOW(a_stall_only_on_full, clk, rst_n, in_valid_reg && !proc_fire,
        in_last_reg && out_valid_reg && !m_axis_tready,
        "input register stalled without a full result register")
    `EVL4_ASSERT_NOW(a_tag_count_bound, clk, rst_n, phase_reg == PH_VLAN,
        vlan_seen_reg < VW'(MAX_VLAN_TAGS), "tag phase entered past the tag bound")

endmodule

### sim/tb_top.sv
// self-checking testbench for the ethernet / vlan / ipv4 / l4 header parser
`timescale 1ns / 100ps

module tb_top;
    import evl4_pkg::*;

    localparam int TAG_LIMIT    = 2;
    localparam int LEN_BITS     = 16;
    localparam logic [15:0] COUNT_SAT = 16'((1 << LEN_BITS) - 1);
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [3:0] {
        PS_ETH, PS_VLAN, PS_IPH, PS_IPOPT, PS_TCP, PS_UDP,
        PS_NONIP, PS_OTHER, PS_OVF, PS_FRAG, PS_IHL
    } parse_state_t;

    // m_axis_tdata layout, msb first
    typedef struct packed {
        logic [3:0]  spare;
        logic [15:0] trim_len;
        logic [15:0] pay_start;
        logic [7:0]  tcp_flags;
        logic [15:0] dst_port;
        logic [15:0] src_port;
        logic [7:0]  proto;
        logic [31:0] dst_ip;
        logic [31:0] src_ip;
        logic [15:0] ethertype;
        logic [3:0]  status;
    } hdr_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'h00;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [167:0] m_axis_tdata;

    // parser mirror
    parse_state_t ps_state;
    logic [15:0]  byte_cnt;
    logic [2:0]   tags_seen;
    logic [15:0]  etype_acc;
    logic [15:0]  l3_start;
    logic [15:0]  l4_start;
    logic [3:0]   ihl_acc;
    logic [15:0]  ip_len;
    logic [13:0]  frag_acc;
    logic [7:0]   proto_acc;
    logic [31:0]  ip_addr [2];
    logic [15:0]  l4_port [2];
    logic [3:0]   tcp_off;
    logic [7:0]   tcp_flg;

    hdr_result_t  expected_hdrs [$];
    logic [7:0]   frame_q [$];
    int           err_cnt = 0;
    int           bytes_sent = 0;
    bit           idle_en = 1'b1;
    int           stall_left = 0;

    eth_vlan_ipv4_l4_header_parser_core #(
        .MAX_VLAN_TAGS (TAG_LIMIT),
        .LENGTH_BITS   (LEN_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_parse();
        ps_state   = PS_ETH;
        byte_cnt   = '0;
        tags_seen  = '0;
        etype_acc  = '0;
        l3_start   = '0;
        l4_start   = '0;
        ihl_acc    = '0;
        ip_len     = '0;
        frag_acc   = '0;
        proto_acc  = '0;
        ip_addr[0] = '0;
        ip_addr[1] = '0;
        l4_port[0] = '0;
        l4_port[1] = '0;
        tcp_off    = '0;
        tcp_flg    = '0;
    endfunction

    function automatic void pick_next_header();
        if (etype_acc == ETYPE_CTAG || etype_acc == ETYPE_STAG)
            ps_state = (tags_seen >= TAG_LIMIT) ? PS_OVF : PS_VLAN;
        else if (etype_acc == ETYPE_IPV4)
            ps_state = PS_IPH;
        else
            ps_state = PS_NONIP;
    endfunction

    function automatic void pick_l4();
        if (proto_acc == PROTO_TCP)
            ps_state = PS_TCP;
        else if (proto_acc == PROTO_UDP)
            ps_state = PS_UDP;
        else
            ps_state = PS_OTHER;
    endfunction

    // fold one accepted byte into the mirror; a last byte queues the header summary
    task automatic fold_byte(input logic [7:0] b, input logic is_last);
        int unsigned pos;
        int unsigned rel;
        int unsigned len;
        int unsigned lim;
        int unsigned trim;
        int unsigned pay;
        status_t     st;
        hdr_result_t r;
        pos = byte_cnt;
        if (byte_cnt < COUNT_SAT)
            byte_cnt++;
        case (ps_state)
            PS_ETH:
            begin
                if (pos == 12)
                    etype_acc = {b, 8'h00};
                else if (pos == 13)
                begin
                    etype_acc |= b;
                    l3_start = ETH_HDR_LEN;
                    pick_next_header();
                end
            end
            PS_VLAN:
            begin
                rel = pos - l3_start;
                if (rel == 2)
                    etype_acc = {b, 8'h00};
                else if (rel == 3)
                begin
                    etype_acc |= b;
                    l3_start += VLAN_TAG_LEN;
                    tags_seen++;
                    pick_next_header();
                end
            end
            PS_IPH:
            begin
                rel = pos - l3_start;
                case (rel)
                    0:              ihl_acc = b[3:0];
                    2:              ip_len = {b, 8'h00};
                    3:              ip_len |= b;
                    6:              frag_acc = {b[5:0], 8'h00};
                    7:              frag_acc |= b;
                    9:              proto_acc = b;
                    12, 13, 14, 15: ip_addr[0] = {ip_addr[0][23:0], b};
                    16, 17, 18, 19: ip_addr[1] = {ip_addr[1][23:0], b};
                    default:        ;
                endcase
                // fragment beats bad ihl when both apply
                if (rel == 19)
                begin
                    if (frag_acc != 0)
                        ps_state = PS_FRAG;
                    else if (ihl_acc < IHL_MIN)
                        ps_state = PS_IHL;
                    else
                    begin
                        l4_start = l3_start + ihl_acc * 4;
                        if (ihl_acc == IHL_MIN)
                            pick_l4();
                        else
                            ps_state = PS_IPOPT;
                    end
                end
            end
            PS_IPOPT:
            begin
                if (pos + 1 >= l4_start)
                    pick_l4();
            end
            PS_TCP, PS_UDP:
            begin
                rel = pos - l4_start;
                if (rel <= 1)
                    l4_port[0] = {l4_port[0][7:0], b};
                else if (rel <= 3)
                    l4_port[1] = {l4_port[1][7:0], b};
                else if (ps_state == PS_TCP && rel == 12)
                    tcp_off = b[7:4];
                else if (ps_state == PS_TCP && rel == 13)
                    tcp_flg = b;
            end
            default: ;
        endcase
        if (!is_last)
            return;

        len  = byte_cnt;
        lim  = l3_start + ip_len;
        trim = (lim < len) ? lim : len;
        pay  = l3_start;
        case (ps_state)
            PS_ETH:
            begin
                st = ST_ETH_SHORT;
                pay = 0;
                trim = len;
            end
            PS_VLAN:
            begin
                st = ST_ETH_SHORT;
                trim = len;
            end
            PS_NONIP:
            begin
                st = ST_NON_IPV4;
                trim = len;
            end
            PS_OVF:
            begin
                st = ST_VLAN_OVF;
                trim = len;
            end
            PS_FRAG:
            begin
                st = ST_FRAGMENT;
                trim = len;
            end
            PS_IHL:
            begin
                st = ST_BAD_IHL;
                trim = len;
            end
            PS_IPH, PS_IPOPT:
            begin
                st = ST_IP_SHORT;
                trim = len;
            end
            PS_OTHER:
            begin
                st = ST_OTHER_PROTO;
                pay = l4_start;
            end
            PS_UDP:
            begin
                pay = l4_start;
                if (trim < l4_start + UDP_HDR_LEN)
                    st = ST_L4_SHORT;
                else
                begin
                    st = ST_L4_OK;
                    pay = l4_start + UDP_HDR_LEN;
                end
            end
            default:
            begin
                // tcp: minimum header, then offset sanity, then full header length
                pay = l4_start;
                if (trim < l4_start + TCP_HDR_MIN)
                    st = ST_L4_SHORT;
                else if (tcp_off < TCP_OFF_MIN)
                    st = ST_BAD_TCP_OFF;
                else if (trim < l4_start + tcp_off * 4)
                    st = ST_L4_SHORT;
                else
                begin
                    st = ST_L4_OK;
                    pay = l4_start + tcp_off * 4;
                end
            end
        endcase
        r.spare     = '0;
        r.status    = st;
        r.ethertype = etype_acc;
        r.src_ip    = ip_addr[0];
        r.dst_ip    = ip_addr[1];
        r.proto     = proto_acc;
        r.src_port  = l4_port[0];
        r.dst_port  = l4_port[1];
        r.tcp_flags = tcp_flg;
        r.pay_start = pay[15:0];
        r.trim_len  = trim[15:0];
        expected_hdrs.push_back(r);
        clear_parse();
    endtask

    function automatic string hdr_text(input hdr_result_t h);
        return $sformatf("st=%0d et=%h src=%h dst=%h pr=%h sp=%h dp=%h fl=%h pay=%0d len=%0d sp=%h",
                         h.status, h.ethertype, h.src_ip, h.dst_ip, h.proto, h.src_port,
                         h.dst_port, h.tcp_flags, h.pay_start, h.trim_len, h.spare);
    endfunction

    task automatic check_hdr(input hdr_result_t got);
        hdr_result_t want;
        if (expected_hdrs.size() == 0)
        begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("unexpected result beat: %s", hdr_text(got));
            return;
        end
        want = expected_hdrs.pop_front();
        if (got.status !== want.status || got.ethertype !== want.ethertype ||
            got.src_ip !== want.src_ip || got.dst_ip !== want.dst_ip ||
            got.proto !== want.proto || got.src_port !== want.src_port ||
            got.dst_port !== want.dst_port || got.tcp_flags !== want.tcp_flags ||
            got.pay_start !== want.pay_start || got.trim_len !== want.trim_len ||
            got.spare !== want.spare)
        begin
            err_cnt++;
            if (err_cnt <= 10)
            begin
                $display("result mismatch");
                $display("  expected %s", hdr_text(want));
                $display("  actual   %s", hdr_text(got));
            end
        end
    endtask

    // inputs settle after the rising edge, so the negedge sees what the next edge takes
    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_hdr(m_axis_tdata);
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (idle_en && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 3);
        m_axis_tready <= (stall_left == 0);
    end

    // called at a rising edge, returns at the edge that takes the beat
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= is_last;
        forever
        begin
            @(negedge clk);
            if (s_axis_tready)
                break;
            @(posedge clk);
        end
        fold_byte(b, is_last);
        bytes_sent++;
        @(posedge clk);
    endtask

    task automatic send_frame;
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_hdrs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // macs, tags, ethertype, ipv4 header, l4 header, payload, padding; then optional cut
    task automatic build_frame(input int n_tags, input logic [15:0] etype,
                               input logic [3:0] ihl, input logic [13:0] frag,
                               input logic [7:0] proto, input logic [3:0] doff,
                               input int pay_len, input int len_adj,
                               input int pad_len, input int cut_len);
        int ip_hlen;
        int l4_len;
        int ip_total;
        logic [15:0] tpid;
        logic [15:0] udp_len;
        frame_q.delete();
        repeat (12) frame_q.push_back(8'($urandom));
        for (int i = 0; i < n_tags; i++)
        begin
            tpid = $urandom_range(0, 1) ? ETYPE_CTAG : ETYPE_STAG;
            frame_q.push_back(tpid[15:8]);
            frame_q.push_back(tpid[7:0]);
            frame_q.push_back(8'($urandom));
            frame_q.push_back(8'($urandom));
        end
        frame_q.push_back(etype[15:8]);
        frame_q.push_back(etype[7:0]);

        ip_hlen = (ihl >= IHL_MIN) ? ihl * 4 : 20;
        if (proto == PROTO_TCP)
            l4_len = (doff > TCP_OFF_MIN) ? doff * 4 : TCP_HDR_MIN;
        else
            l4_len = UDP_HDR_LEN;
        ip_total = ip_hlen + l4_len + pay_len + len_adj;
        if (ip_total < 0)
            ip_total = 0;
        if (ip_total > 65535)
            ip_total = 65535;

        frame_q.push_back({4'($urandom), ihl});
        frame_q.push_back(8'($urandom));
        frame_q.push_back(8'(ip_total >> 8));
        frame_q.push_back(8'(ip_total));
        repeat (2) frame_q.push_back(8'($urandom));
        // df and the reserved bit sit above the fragment field and must be ignored
        frame_q.push_back({2'($urandom), frag[13:8]});
        frame_q.push_back(frag[7:0]);
        frame_q.push_back(8'($urandom));
        frame_q.push_back(proto);
        repeat (10 + ip_hlen - 20) frame_q.push_back(8'($urandom));

        if (proto == PROTO_TCP)
        begin
            repeat (12) frame_q.push_back(8'($urandom));
            frame_q.push_back({doff, 4'($urandom)});
            repeat (l4_len - 13) frame_q.push_back(8'($urandom));
        end
        else if (proto == PROTO_UDP)
        begin
            udp_len = 16'(l4_len + pay_len);
            repeat (4) frame_q.push_back(8'($urandom));
            frame_q.push_back(udp_len[15:8]);
            frame_q.push_back(udp_len[7:0]);
            repeat (2) frame_q.push_back(8'($urandom));
        end
        else
            repeat (l4_len) frame_q.push_back(8'($urandom));

        repeat (pay_len) frame_q.push_back(8'($urandom));
        repeat (pad_len) frame_q.push_back(8'h00);
        if (cut_len > 0)
            while (frame_q.size() > cut_len)
                void'(frame_q.pop_back());
    endtask

    task automatic push_frame(input int n_tags, input logic [15:0] etype,
                              input logic [3:0] ihl, input logic [13:0] frag,
                              input logic [7:0] proto, input logic [3:0] doff,
                              input int pay_len, input int len_adj,
                              input int pad_len, input int cut_len);
        build_frame(n_tags, etype, ihl, frag, proto, doff, pay_len, len_adj, pad_len, cut_len);
        send_frame;
    endtask

    // mostly well formed frames with random content, some broken ones and some noise
    task automatic random_frame;
        int sel;
        int n_tags;
        logic [15:0] etype;
        logic [3:0] ihl;
        logic [13:0] frag;
        logic [7:0] proto;
        logic [3:0] doff;
        int len_adj;
        sel = $urandom_range(0, 99);
        if (sel < 8)
        begin
            frame_q.delete();
            repeat ($urandom_range(1, 40)) frame_q.push_back(8'($urandom));
            return;
        end
        sel = $urandom_range(0, 9);
        n_tags = (sel < 4) ? 0 : (sel < 7) ? 1 : (sel < 9) ? 2 : 3;
        etype = ($urandom_range(0, 9) == 0) ? 16'($urandom) : ETYPE_IPV4;
        sel = $urandom_range(0, 9);
        if (sel < 8)
            ihl = IHL_MIN;
        else if (sel == 8)
            ihl = $urandom_range(6, 15);
        else
            ihl = $urandom_range(0, 4);
        frag = ($urandom_range(0, 9) == 0) ? 14'($urandom) : 14'd0;
        sel = $urandom_range(0, 9);
        proto = (sel < 4) ? PROTO_TCP : (sel < 8) ? PROTO_UDP : 8'($urandom);
        doff = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(5, 8));
        sel = $urandom_range(0, 9);
        if (sel < 7)
            len_adj = 0;
        else if (sel < 9)
            len_adj = -int'($urandom_range(1, 30));
        else
            len_adj = $urandom_range(1, 30);
        build_frame(n_tags, etype, ihl, frag, proto, doff, $urandom_range(0, 12), len_adj,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0,
                    ($urandom_range(0, 4) == 0) ? $urandom_range(1, 70) : 0);
    endtask

    task automatic test_eth_short;
        push_frame(0, ETYPE_IPV4, 5, 0, PROTO_UDP, 5, 0, 0, 0, 1);
        push_frame(0, ETYPE_IPV4, 5, 0, PROTO_UDP, 5, 0, 0, 0, 13);
        // cut inside a tag, before and within its inner type
        push_frame(1, ETYPE_IPV4, 5, 0, PROTO_UDP, 5, 0, 0, 0, 16);
        push_frame(2, ETYPE_IPV4, 5, 0, PROTO_UDP, 5, 0, 0, 0, 21);
    endtask

    task automatic test_non_ipv4;
        push_frame(0, 16'h86DD, 5, 0, PROTO_TCP, 5, 20, 0, 0, 0);
        push_frame(1, 16'hFFFF, 5, 0, PROTO_UDP, 5, 0, 0, 0, 0);
    endtask

    task automatic test_vlan_stack;
        push_frame(1, ETYPE_IPV4, 5, 0, PROTO_UDP, 5, 4, 0, 0, 0);
        push_frame(2, ETYPE_IPV4, 5, 0, PROTO_TCP, 5, 3, 0, 0, 0);
        // one tag too many ends the parse whatever follows
        push_frame(3, ETYPE_IPV4, 5, 0, PROTO_TCP, 5, 3, 0, 0, 0);
    endtask

    task automatic test_ip_short;
        push_frame(0, ETYPE_IPV4, 5, 0, PROTO_UDP, 5, 0, 0, 0, 24);
        push_frame(0, ETYPE_IPV4, 6, 0, PROTO_UDP, 5, 0, 0, 0, 36);
    endtask

    task automatic test_fragment;
        push_frame(0, ETYPE_IPV4, 5, 14'h2000, PROTO_UDP, 5, 0, 0, 0, 0);
        push_frame(0, ETYPE_IPV4, 5, 14'h00B9, PROTO_TCP, 5, 0, 0, 0, 0);
        push_frame(1, ETYPE_IPV4, 3, 14'h3FFF, PROTO_TCP, 5, 0, 0, 0, 0);
    endtask

    task automatic test_bad_ihl;
        push_frame(0, ETYPE_IPV4, 0, 0, PROTO_UDP, 5, 0, 0, 0, 0);
        push_frame(0, ETYPE_IPV4, 4, 0, PROTO_TCP, 5, 0, 0, 0, 0);
    endtask

    task automatic test_ip_options;
        push_frame(0, ETYPE_IPV4, 15, 0, PROTO_UDP, 5, 2, 0, 0, 0);
        push_frame(2, ETYPE_IPV4, 7, 0, PROTO_TCP, 6, 1, 0, 0, 0);
    endtask

    task automatic test_udp;
        push_frame(0, ETYPE_IPV4, 5, 0, PROTO_UDP, 5, 6, 0, 0, 0);
        // ethernet padding beyond the ip total length is trimmed off
        push_frame(0, ETYPE_IPV4, 5, 0, PROTO_UDP, 5, 2, 0, 10, 0);
        push_frame(0, ETYPE_IPV4, 5, 0, PROTO_UDP, 5, 0, -1, 12, 0);
        push_frame(0, ETYPE_IPV4, 5, 0, PROTO_UDP, 5, 0, 9, 0, 0);
    endtask

    task automatic test_tcp;
        push_frame(0, ETYPE_IPV4, 5, 0, PROTO_TCP, 5, 0, 0, 0, 0);
        push_frame(0, ETYPE_IPV4, 5, 0, PROTO_TCP, 15, 1, 0, 0, 0);
        push_frame(0, ETYPE_IPV4, 5, 0, PROTO_TCP, 4, 5, 0, 0, 0);
        push_frame(0, ETYPE_IPV4, 5, 0, PROTO_TCP, 8, 0, -5, 6, 0);
        push_frame(0, ETYPE_IPV4, 5, 0, PROTO_TCP, 5, 0, 0, 0, 49);
    endtask

    task automatic test_other_proto;
        push_frame(0, ETYPE_IPV4, 5, 0, 8'd1, 5, 4, 0, 0, 0);
        push_frame(1, ETYPE_IPV4, 6, 0, 8'hFF, 5, 0, 0, 3, 0);
    endtask

    // longer than the byte counter can count
    task automatic test_long_frame;
        push_frame(0, ETYPE_IPV4, 5, 0, PROTO_UDP, 5, 65560, 0, 0, 0);
    endtask

    task automatic test_random;
        int frames;
        int first_byte;
        frames = 0;
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < 1150 || frames < 40)
        begin
            idle_en = ($urandom_range(0, 4) != 0);
            random_frame;
            send_frame;
            frames++;
            if (frames == 20)
                drain_results;
        end
    endtask

    task automatic test_no_idle;
        int first_byte;
        first_byte = bytes_sent;
        idle_en = 1'b0;
        while (bytes_sent - first_byte < 300)
        begin
            random_frame;
            send_frame;
        end
    endtask

    initial
    begin
        clear_parse();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_eth_short;
        test_non_ipv4;
        test_vlan_stack;
        test_ip_short;
        test_fragment;
        test_bad_ihl;
        test_ip_options;
        test_udp;
        test_tcp;
        test_other_proto;
        test_long_frame;
        test_random;
        test_no_idle;
        drain_results;
        if (expected_hdrs.size() != 0)
            err_cnt++;
        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
